/* rtl/sdrr_pkg.sv */
// Package for the SHiP/DIP/RRIP replacement engine.
// Holds the transaction payload structs, fixed constants and the signature hash; no dependencies.
package sdrr_pkg;

    typedef struct packed {
        logic [1:0]  func;
        logic [10:0] set_index;
        logic [3:0]  way_index;
        logic [17:0] pc_low;
        logic        hit;
    } t_req;

    typedef struct packed {
        logic [3:0] victim_way;
        logic [9:0] psel_value;
    } t_rsp;

    localparam logic [1:0] FUNC_VICTIM = 2'd0;
    localparam logic [1:0] FUNC_UPDATE = 2'd1;
    localparam logic [1:0] FUNC_DECAY  = 2'd2;

    localparam logic [1:0] RRPV_MAX = 2'd3;
    localparam logic [9:0] PSEL_MID = 10'd512;
    localparam logic [9:0] PSEL_TOP = 10'd1023;
    localparam int         SIG_W    = 6;
    localparam int         SHIP_N   = 64;

    // Signature hash of the program counter low bits.
    function automatic logic [5:0] sig_of(input logic [17:0] pc);
        sig_of = pc[5:0] ^ pc[11:6] ^ pc[17:12];
    endfunction

endpackage

/* rtl/ship_dip_rrip_replacement.sv */
// Top level of the SHiP/DIP/RRIP replacement engine.
// Steps: victim, update and no-op go from acceptance through row read, SHiP read,
// modify/write and respond; decay reads, waits for and writes back each row in turn.
// Flow: one transaction at a time; a stalled response holds off the next request.
// Reset: a clearing pass rewrites every row (RRPV 3, signature 0,
// reuse 0) and the 64-entry SHiP table; no transaction is accepted until it ends.
// Depends on sdrr_pkg.
module ship_dip_rrip_replacement
    import sdrr_pkg::*;
#(
    parameter int SETS = 2048,
    parameter int WAYS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

    localparam int SW    = $clog2(SETS);
    localparam int WW    = $clog2(WAYS);
    localparam int ROW_W = WAYS * 10;

    // Per-way entry: rrpv[9:8], signature[7:2], reuse[1:0].
    typedef logic [ROW_W-1:0] t_row;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_SHIP, S_MOD, S_DEC_RD, S_DEC_WR, S_RESP
    } t_state;

    t_row              r_mem [SETS];
    t_row              r_rdata;
    logic              r_we;
    logic [SW-1:0]     r_waddr;
    t_row              r_wdata;
    logic [SW-1:0]     r_raddr;
    logic              r_re;

    logic [1:0]        r_ship_mem [SHIP_N];
    logic [1:0]        r_ship_rd;

    t_state            r_state;
    t_req              r_req;
    logic [SW:0]       r_cnt;
    logic [9:0]        r_psel;
    logic [4:0]        r_bip;
    t_rsp              r_rsp;

    // Synchronous row memory with registered read.
    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_mem[r_waddr] <= r_wdata;
        end
        if (r_re) begin
            r_rdata <= r_mem[r_raddr];
        end
    end

    // Request decode.
    logic             set_ok;
    logic             way_ok;
    logic [SW-1:0]    set_i;
    logic [WW-1:0]    way_i;
    logic             lip_lead;
    logic             bip_lead;
    logic [SIG_W-1:0] sig_n;

    always_comb begin
        set_ok   = {21'd0, r_req.set_index} < SETS;
        way_ok   = {28'd0, r_req.way_index} < WAYS;
        set_i    = SW'(r_req.set_index);
        way_i    = WW'(r_req.way_index);
        lip_lead = ({21'd0, r_req.set_index} < SETS / 2) && (r_req.set_index[4:0] == 5'd0);
        bip_lead = ({21'd0, r_req.set_index} < SETS / 2) && (r_req.set_index[4:0] == 5'd1);
        sig_n    = sig_of(r_req.pc_low);
    end

    // Victim search: age the row so the largest RRPV becomes 3, pick lowest such way.
    t_row          aged_row;
    logic [1:0]    top;
    logic [1:0]    add;
    logic [3:0]    vict;
    logic          found;

    always_comb begin
        aged_row = r_rdata;
        top      = 2'd0;
        for (int w = 0; w < WAYS; w++) begin
            if (r_rdata[w*10+8 +: 2] > top) top = r_rdata[w*10+8 +: 2];
        end
        add   = RRPV_MAX - top;
        vict  = 4'd0;
        found = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            aged_row[w*10+8 +: 2] = r_rdata[w*10+8 +: 2] + add;
            if (!found && aged_row[w*10+8 +: 2] == RRPV_MAX) begin
                vict  = 4'(w);
                found = 1'b1;
            end
        end
    end

    // Update of one way: hit promotion or fill insertion.
    t_row             upd_row;
    logic [9:0]       ent;
    logic [SIG_W-1:0] old_sig;
    logic [1:0]       ins;
    logic [9:0]       n_psel;
    logic [4:0]       n_bip;
    logic [SIG_W-1:0] ship_idx;
    logic [1:0]       n_ship;

    always_comb begin
        upd_row  = r_rdata;
        ent      = r_rdata[way_i*10 +: 10];
        old_sig  = ent[7:2];
        n_psel   = r_psel;
        n_bip    = r_bip;
        ins      = RRPV_MAX;
        // A hit trains the entry of the stored signature, a fill that of the new one.
        ship_idx = r_req.hit ? old_sig : sig_n;
        n_ship   = r_ship_rd;
        if (r_req.hit) begin
            n_ship = (r_ship_rd < 2'd3) ? r_ship_rd + 2'd1 : r_ship_rd;
            upd_row[way_i*10 +: 10] = {2'd0, old_sig,
                                       (ent[1:0] < 2'd3) ? ent[1:0] + 2'd1 : ent[1:0]};
            if (lip_lead && r_psel < PSEL_TOP) n_psel = r_psel + 10'd1;
            if (bip_lead && r_psel > 10'd0)    n_psel = r_psel - 10'd1;
        end else begin
            if (lip_lead) begin
                ins = RRPV_MAX;
            end else if (bip_lead) begin
                ins   = (r_bip == 5'd0) ? 2'd0 : RRPV_MAX;
                n_bip = r_bip + 5'd1;
            end else begin
                ins = (r_psel >= PSEL_MID) ? RRPV_MAX : 2'd0;
            end
            if (r_ship_rd >= 2'd2) ins = 2'd0;
            if (ent[1:0] >= 2'd2)  ins = 2'd0;
            upd_row[way_i*10 +: 10] = {ins, sig_n, 2'd0};
            n_ship = (r_ship_rd > 2'd0) ? r_ship_rd - 2'd1 : r_ship_rd;
            if (lip_lead && r_psel > 10'd0)    n_psel = r_psel - 10'd1;
            if (bip_lead && r_psel < PSEL_TOP) n_psel = r_psel + 10'd1;
        end
    end

    // Decay of one row.
    t_row dec_row;
    t_row clr_row;

    always_comb begin
        dec_row = r_rdata;
        clr_row = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (r_rdata[w*10 +: 2] != 2'd0) dec_row[w*10 +: 2] = r_rdata[w*10 +: 2] - 2'd1;
            clr_row[w*10+8 +: 2] = RRPV_MAX;
        end
    end

    // Row write and read strobes, and the SHiP table write port.
    logic             victim_ok;
    logic             update_ok;
    logic             n_we;
    logic             n_re;
    logic             ship_we;
    logic [SIG_W-1:0] ship_waddr;
    logic [1:0]       ship_wdata;

    always_comb begin
        victim_ok  = (r_req.func == FUNC_VICTIM) && set_ok;
        update_ok  = (r_req.func == FUNC_UPDATE) && set_ok && way_ok;
        n_re       = ((r_state == S_IDLE) && i_valid && (i_req.func != FUNC_DECAY))
                     || (r_state == S_DEC_RD);
        n_we       = (r_state == S_CLEAR)
                     || ((r_state == S_MOD) && (victim_ok || update_ok))
                     || ((r_state == S_DEC_WR) && !r_re);
        ship_we    = ((r_state == S_CLEAR) && (r_cnt < (SW+1)'(SHIP_N)))
                     || ((r_state == S_MOD) && update_ok);
        ship_waddr = (r_state == S_CLEAR) ? r_cnt[SIG_W-1:0] : ship_idx;
        ship_wdata = (r_state == S_CLEAR) ? 2'd1 : n_ship;
    end

    // SHiP table memory; the entry for the current request is read once the row is in.
    always_ff @(posedge i_clk) begin
        if (ship_we) begin
            r_ship_mem[ship_waddr] <= ship_wdata;
        end
        r_ship_rd <= r_ship_mem[ship_idx];
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_RESP);
    assign o_rsp   = r_rsp;

    // Sequencer, counters and memory control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_we    <= 1'b0;
            r_re    <= 1'b0;
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_psel  <= PSEL_MID;
            r_bip   <= 5'd0;
        end else begin
            r_we <= n_we;
            r_re <= n_re;
            case (r_state)
                S_CLEAR: begin
                    r_waddr <= r_cnt[SW-1:0];
                    r_wdata <= clr_row;
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == (SW+1)'(SETS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_req <= i_req;
                        if (i_req.func == FUNC_DECAY) begin
                            r_cnt   <= '0;
                            r_state <= S_DEC_RD;
                        end else begin
                            r_raddr <= SW'(i_req.set_index);
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_SHIP;
                end
                S_SHIP: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_rsp.victim_way <= victim_ok ? vict : 4'd0;
                    r_rsp.psel_value <= update_ok ? n_psel : r_psel;
                    if (victim_ok) begin
                        r_waddr <= set_i;
                        r_wdata <= aged_row;
                    end else if (update_ok) begin
                        r_waddr <= set_i;
                        r_wdata <= upd_row;
                        r_psel  <= n_psel;
                        r_bip   <= n_bip;
                    end
                    r_state <= S_RESP;
                end
                S_DEC_RD: begin
                    r_raddr <= r_cnt[SW-1:0];
                    r_state <= S_DEC_WR;
                end
                S_DEC_WR: begin
                    // Wait for the read data, then write the decayed row.
                    if (!r_re) begin
                        r_waddr <= r_cnt[SW-1:0];
                        r_wdata <= dec_row;
                        r_cnt   <= r_cnt + 1'b1;
                        if (r_cnt == (SW+1)'(SETS - 1)) begin
                            r_rsp.victim_way <= 4'd0;
                            r_rsp.psel_value <= r_psel;
                            r_state          <= S_RESP;
                        end else begin
                            r_state <= S_DEC_RD;
                        end
                    end
                end
                S_RESP: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
